/* rtl/csem_pkg.sv */
// Shared field widths, command and status codes for the semaphore wait-queue unit.
package csem_pkg;

   // Transaction field widths
   localparam int CMD_W     = 1;
   localparam int RES_IDX_W = 3;
   localparam int PID_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int LEFT_W    = 9;
   localparam int CFG_W     = 8;

   // Control register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Upper limit of an instance count
   localparam logic signed [LEFT_W-1:0] COUNT_MAX = 9'sd255;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WAIT   = 1'b0;
   localparam logic [CMD_W-1:0] CMD_SIGNAL = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

/* rtl/csem_req_if.sv */
// Request channel: command, resource index and process id.
interface csem_req_if;
   import csem_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [RES_IDX_W-1:0] resource_index;
   logic [PID_W-1:0]     process_id;

   modport source (output valid, command, resource_index, process_id, input ready);
   modport sink   (input valid, command, resource_index, process_id, output ready);
endinterface

/* rtl/csem_rsp_if.sv */
// Response channel: status, woken process and remaining instance count.
interface csem_rsp_if;
   import csem_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic                     woken_valid;
   logic [PID_W-1:0]         woken_pid;
   logic signed [LEFT_W-1:0] instances_left;

   modport source (output valid, status, woken_valid, woken_pid, instances_left,
                   input ready);
   modport sink   (input valid, status, woken_valid, woken_pid, instances_left,
                   output ready);
endinterface

/* rtl/csem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/counting_semaphore_wait_queue.sv */
// Counting semaphore unit with a FIFO wait queue per resource (top level).
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+------------------------------------------
//  req     | in        | valid / ready    | command, resource_index, process_id
//  rsp     | out       | valid / ready    | status, woken_valid, woken_pid, instances_left
//  csr     | in        | APB psel/penable | resN_instances at byte address 4*N
//
//  One transaction per cycle sustained while rsp is not stalled; a response is
//  registered after the request is taken (input register, then result register).
//  The wait-queue RAM read is issued at acceptance with the head pointer of the
//  transaction in flight forwarded; a same-cycle write to that slot is bypassed.
//  Reset clears counts, queue pointers, fill levels, configuration and valid flags;
//  queue storage and payload registers are not cleared. A stalled response holds the input stage; requests back up.
module counting_semaphore_wait_queue #(
   parameter int NUM_RESOURCES = 4,
   parameter int QUEUE_DEPTH   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   csem_req_if.sink                        req,
   csem_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [csem_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [csem_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [csem_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import csem_pkg::*;

   localparam int RES_W     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef logic signed [LEFT_W-1:0] count_type;

   // Advance a circular queue pointer
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] nxt;
      nxt = PTR_W'(p + 1'b1);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : nxt;
   endfunction

   // Flat RAM address of a slot of a resource's queue
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [RES_W-1:0] r,
                                                   input logic [PTR_W-1:0] p);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(r) * ADDR_W'(QUEUE_DEPTH));
      return ADDR_W'(base + ADDR_W'(p));
   endfunction

   // Per-resource state
   count_type         count_ff [NUM_RESOURCES];
   count_type         count_in [NUM_RESOURCES];
   logic [PTR_W-1:0]  head_ff  [NUM_RESOURCES];
   logic [PTR_W-1:0]  head_in  [NUM_RESOURCES];
   logic [PTR_W-1:0]  tail_ff  [NUM_RESOURCES];
   logic [PTR_W-1:0]  tail_in  [NUM_RESOURCES];
   logic [FILL_W-1:0] fill_ff  [NUM_RESOURCES];
   logic [FILL_W-1:0] fill_in  [NUM_RESOURCES];
   logic [CFG_W-1:0]  cfg_ff   [NUM_RESOURCES];
   logic [CFG_W-1:0]  cfg_in   [NUM_RESOURCES];

   // Input stage
   logic                 in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic                 res_ok_ff;
   logic [RES_W-1:0]     res_ff;
   logic [PID_W-1:0]     pid_ff;

   // Result stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 woken_valid_ff, woken_valid_in;
   logic [PID_W-1:0]     woken_pid_ff, woken_pid_in;
   count_type            left_ff, left_in;

   // Queue RAM and read bypass
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [PID_W-1:0]     wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [PID_W-1:0]     rd_data;
   logic                 byp_hit_ff, byp_hit_in;
   logic [PID_W-1:0]     byp_data_ff;

   // Handshake and decode
   logic                 out_free, fire, req_fire;
   logic                 req_res_ok;
   logic [RES_W-1:0]     req_res, rd_res;
   logic                 cfg_we, cfg_ok;
   logic [1:0]           cfg_idx;
   logic [RES_W-1:0]     cfg_res;

   // Working values of the resource in the input stage
   count_type            cnt, cnt_up;
   logic [FILL_W-1:0]    fill;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign fire       = in_valid_ff && out_free;
   assign req.ready  = !in_valid_ff || out_free;
   assign req_fire   = req.valid && req.ready;
   assign req_res_ok = req.resource_index < RES_IDX_W'(NUM_RESOURCES);
   assign req_res    = req_res_ok ? req.resource_index[RES_W-1:0] : '0;

   // Decode the register port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[3:2];
   assign cfg_ok     = {1'b0, cfg_idx} < 3'(NUM_RESOURCES);
   assign cfg_res    = cfg_ok ? cfg_idx[RES_W-1:0] : '0;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && cfg_ok;
   assign csr_prdata = cfg_ok ? CSR_DATA_W'(cfg_ff[cfg_res]) : '0;

   assign cnt    = count_ff[res_ff];
   assign fill   = fill_ff[res_ff];
   assign cnt_up = (cnt < COUNT_MAX) ? count_type'(cnt + 9'sd1) : cnt;

   // Execute the command in the input stage and apply register writes
   always_comb begin
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      cfg_in         = cfg_ff;
      wr_en          = 1'b0;
      wr_addr        = slot_addr(res_ff, tail_ff[res_ff]);
      wr_data        = pid_ff;
      status_in      = ST_INVALID;
      woken_valid_in = 1'b0;
      woken_pid_in   = '0;
      left_in        = '0;

      if (fire && res_ok_ff) begin
         case (cmd_ff)
            CMD_WAIT: begin
               if (cnt > 9'sd0) begin
                  count_in[res_ff] = count_type'(cnt - 9'sd1);
                  status_in        = ST_GRANTED;
                  left_in          = count_type'(cnt - 9'sd1);
               end else if (fill >= FILL_W'(QUEUE_DEPTH)) begin
                  status_in = ST_FULL;
                  left_in   = cnt;
               end else begin
                  wr_en            = 1'b1;
                  tail_in[res_ff]  = next_slot(tail_ff[res_ff]);
                  fill_in[res_ff]  = FILL_W'(fill + 1'b1);
                  count_in[res_ff] = count_type'(cnt - 9'sd1);
                  status_in        = ST_QUEUED;
                  left_in          = count_type'(cnt - 9'sd1);
               end
            end
            CMD_SIGNAL: begin
               count_in[res_ff] = cnt_up;
               status_in        = ST_RELEASED;
               left_in          = cnt_up;
               // Hand the instance to the oldest waiter
               if (cnt_up <= 9'sd0 && fill != '0) begin
                  woken_valid_in  = 1'b1;
                  woken_pid_in    = byp_hit_ff ? byp_data_ff : rd_data;
                  head_in[res_ff] = next_slot(head_ff[res_ff]);
                  fill_in[res_ff] = FILL_W'(fill - 1'b1);
               end
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end

      // Reload a resource on a register write
      if (cfg_we) begin
         cfg_in[cfg_res]   = csr_pwdata[CFG_W-1:0];
         count_in[cfg_res] = count_type'({1'b0, csr_pwdata[CFG_W-1:0]});
         head_in[cfg_res]  = '0;
         tail_in[cfg_res]  = '0;
         fill_in[cfg_res]  = '0;
      end
   end

   // Issue the head read for the next transaction, forwarding pointer updates
   assign rd_res     = req_fire ? req_res : res_ff;
   assign rd_addr    = slot_addr(rd_res, head_in[rd_res]);
   assign byp_hit_in = wr_en && (wr_addr == rd_addr);

   assign in_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   csem_ram #(
      .WIDTH (PID_W),
      .DEPTH (MEM_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
         for (int i = 0; i < NUM_RESOURCES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            cfg_ff[i]   <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_hit_ff   <= byp_hit_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
      if (req_fire) begin
         cmd_ff    <= req.command;
         res_ok_ff <= req_res_ok;
         res_ff    <= req_res;
         pid_ff    <= req.process_id;
      end
      if (fire) begin
         status_ff      <= status_in;
         woken_valid_ff <= woken_valid_in;
         woken_pid_ff   <= woken_pid_in;
         left_ff        <= left_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.woken_valid    = woken_valid_ff;
   assign rsp.woken_pid      = woken_pid_ff;
   assign rsp.instances_left = left_ff;
endmodule
